// ----- src/iscfp_pkg.sv -----
package iscfp_pkg;

	// Frame layout
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] KIND_FIRST  = 8'h50;
	localparam logic [7:0] KIND_LAST   = 8'h59;
	localparam int unsigned FRAME_LEN   = 11;
	localparam int unsigned SUM_LEN     = 10;
	localparam int unsigned PAYLOAD_LEN = 8;

	localparam int unsigned POS_W     = 4;
	localparam int unsigned PAYLOAD_W = PAYLOAD_LEN * 8;

	// Frame status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_KIND     = 2'd2;

	// One completed frame, as handed from the assembler to the output register.
	typedef struct packed {
		logic                 valid;
		logic [1:0]           status;
		logic [3:0]           kind;
		logic [PAYLOAD_W-1:0] payload;
	} frame_res_t;

endpackage

// ----- src/iscfp_asm.sv -----
module iscfp_asm (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               rx_byte,
	output iscfp_pkg::frame_res_t    res
);

	logic [iscfp_pkg::POS_W-1:0]     pos_q;
	logic [7:0]                      sum_q;
	logic [7:0]                      kind_q;
	logic [iscfp_pkg::PAYLOAD_W-1:0] payload_q;

	logic                            at_start;
	logic                            at_end;
	logic                            kind_ok;
	logic [7:0]                      sum_next;
	logic [7:0]                      kind_off;

	assign at_start = (pos_q == '0) ||
		(pos_q >= iscfp_pkg::POS_W'(iscfp_pkg::FRAME_LEN));
	assign at_end   = (pos_q == iscfp_pkg::POS_W'(iscfp_pkg::SUM_LEN));
	assign sum_next = sum_q + rx_byte;
	assign kind_ok  = (kind_q >= iscfp_pkg::KIND_FIRST) && (kind_q <= iscfp_pkg::KIND_LAST);
	assign kind_off = kind_q - iscfp_pkg::KIND_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			kind_q    <= '0;
			payload_q <= '0;
		end else if (accept) begin
			if (at_start) begin
				if (rx_byte == iscfp_pkg::HEADER_BYTE) begin
					pos_q     <= iscfp_pkg::POS_W'(1);
					sum_q     <= iscfp_pkg::HEADER_BYTE;
					kind_q    <= '0;
					payload_q <= '0;
				end else begin
					pos_q <= '0;
				end
			end else if (at_end) begin
				pos_q     <= '0;
				sum_q     <= '0;
				kind_q    <= '0;
				payload_q <= '0;
			end else begin
				if (pos_q == iscfp_pkg::POS_W'(1)) begin
					kind_q <= rx_byte;
				end
				// Payload bytes land in their own lane, frame byte 2 lowest.
				for (int i = 0; i < iscfp_pkg::PAYLOAD_LEN; i++) begin
					if (pos_q == iscfp_pkg::POS_W'(i + 2)) begin
						payload_q[i*8 +: 8] <= rx_byte;
					end
				end
				sum_q <= sum_next;
				pos_q <= pos_q + iscfp_pkg::POS_W'(1);
			end
		end
	end

	always_comb begin
		res.valid   = accept && at_end;
		res.payload = payload_q;
		res.kind    = kind_ok ? kind_off[3:0] : 4'd0;
		if (sum_q != rx_byte) begin
			res.status = iscfp_pkg::ST_CHECKSUM;
		end else if (!kind_ok) begin
			res.status = iscfp_pkg::ST_KIND;
		end else begin
			res.status = iscfp_pkg::ST_OK;
		end
	end

endmodule

// ----- src/iscfp_out.sv -----
module iscfp_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iscfp_pkg::frame_res_t             res,
	output logic                              room,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        out_status,
	output logic [3:0]                        out_kind,
	output logic [iscfp_pkg::PAYLOAD_W-1:0]   out_payload
);

	logic                            valid_q;
	logic [1:0]                      status_q;
	logic [3:0]                      kind_q;
	logic [iscfp_pkg::PAYLOAD_W-1:0] payload_q;

	// The register can take a new frame when empty or when being drained now.
	assign room = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (room && res.valid) begin
			status_q  <= res.status;
			kind_q    <= res.kind;
			payload_q <= res.payload;
		end
	end

	assign out_valid   = valid_q;
	assign out_status  = status_q;
	assign out_kind    = kind_q;
	assign out_payload = payload_q;

endmodule

// ----- src/imu_sum_checked_frame_parser.sv -----
// Channel   | Dir | Signals                            | Moves
// ----------+-----+------------------------------------+-------------------------------
// s_axis    | in  | tvalid, tready, tdata[7:0]         | one received serial byte
// m_axis    | out | tvalid, tready, tdata[63:0], tuser | one result per complete frame
//
// Each byte is handled in the cycle it is accepted; a new byte can be taken every clock while s_axis_tready is high.
// The eleventh byte of a frame produces a result in the output register in the cycle after it is accepted.
// s_axis_tready drops only while the output register holds a result that is not taken.
// Reset (arst_n low) clears the byte position, running sum and the output valid flag.
module imu_sum_checked_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] frame_payload
	output logic [7:0]  m_axis_tuser    // [1:0] frame_status, [5:2] frame_kind, [7:6] zero
);

	// A transaction on the input side is one serial byte.
	logic                  in_accept;
	iscfp_pkg::frame_res_t res;
	logic                  room;
	logic [1:0]            out_status;
	logic [3:0]            out_kind;

	assign s_axis_tready = room;
	assign in_accept     = s_axis_tvalid && room;

	// The assembler keeps the byte position, running checksum, kind byte and
	// payload, and forms the result combinationally when the checksum byte arrives.
	iscfp_asm u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.rx_byte (s_axis_tdata),
		.res     (res)
	);

	// The output register holds a finished frame until it is taken. Bytes keep
	// flowing while it is empty or being drained in the same cycle; while a
	// result waits unread, the input side waits with it.
	iscfp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.room        (room),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (out_status),
		.out_kind    (out_kind),
		.out_payload (m_axis_tdata)
	);

	assign m_axis_tuser = {2'b00, out_kind, out_status};

`ifndef SYNTH
	// The input side only stalls while a result sits unread in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a pending result");

	// A new result appears only after a checksum byte was accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(res.valid))
		else $error("result appeared without a completed frame");

	// A frame marked accepted always carries an in-range kind index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status == iscfp_pkg::ST_OK) |-> (out_kind <= 4'd9))
		else $error("accepted frame with kind out of range");

	// Status never takes the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == iscfp_pkg::ST_OK ||
			res.status == iscfp_pkg::ST_CHECKSUM || res.status == iscfp_pkg::ST_KIND))
		else $error("invalid frame status");
`endif

endmodule
